FILE: src/ddf_pkg.sv
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types and constants of the decimal display formatter: request
// structs, controller/datapath command and status groups, ASCII codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ddf_pkg;

    // Digit limit and display width
    localparam int MAX_DIGITS   = 10;
    localparam int LINE_COLUMNS = 16;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COLUMN_W = 4;
    localparam int CHAR_W   = 8;

    // A 32-bit value has at most ten decimal digits
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int NUM_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

    // Line 1 prints at least "0.dd", i.e. three digit positions
    localparam int FRAC_DIGITS     = 2;
    localparam int MIN_FRAC_DIGITS = FRAC_DIGITS + 1;
    localparam int DISP_DIGITS     = (NUM_DIGITS < MIN_FRAC_DIGITS) ? MIN_FRAC_DIGITS
                                                                    : NUM_DIGITS;

    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int POS_W     = $clog2(DISP_DIGITS);
    localparam int CNT_W     = $clog2(DISP_DIGITS + 2);
    localparam int CALC_W    = 8;

    // ASCII
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'd46;

    // Result kinds
    localparam logic KIND_CURSOR = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    typedef struct packed {
        logic               line;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic                kind;
        logic                row;
        logic [COLUMN_W-1:0] column;
        logic [CHAR_W-1:0]   char_code;
        logic                last;
    } out_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit_cursor;
        logic emit_char;
    } ddf_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic out_free;
        logic last_char;
    } ddf_sts_t;

endpackage

`default_nettype wire

FILE: src/ddf_datapath.sv
// ----------------------------------------------------------------------------
// ddf_datapath
// Shift-and-add-3 binary to BCD converter, digit count, character
// sequencing and the output request register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_datapath
    import ddf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      in_data,
    input  logic     out_stall,
    input  ddf_cmd_t cmd,
    output ddf_sts_t sts,
    output logic     out_valid,
    output out_t     out_data
);

    logic                 line_reg,       line_next;
    logic [VALUE_W-1:0]   value_reg,      value_next;
    logic [BCD_W-1:0]     bcd_reg,        bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg,    bit_cnt_next;
    logic [POS_W-1:0]     pos_reg,        pos_next;
    logic                 point_next_reg, point_next_next;
    logic [COLUMN_W-1:0]  col_reg,        col_next;
    logic                 out_valid_reg,  out_valid_next;
    out_t                 out_data_reg,   out_data_next;

    logic [BCD_W-1:0]  bcd_adj;
    logic [CNT_W-1:0]  nd;
    logic [CNT_W-1:0]  ndisp;
    logic [CNT_W-1:0]  n_chars;
    logic [COLUMN_W-1:0] column;
    logic [3:0]        disp_dig [DISP_DIGITS];
    logic [3:0]        cur_dig;
    logic              at_point;
    logic              last_char;

    // add 3 to every digit >= 5 before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    // significant digit count, then printed digit count and column;
    // a nonzero digit above the limit pins the count at the limit
    always_comb
    begin
        nd = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                nd = (i < NUM_DIGITS) ? CNT_W'(i + 1) : CNT_W'(NUM_DIGITS);
            end
        end
        if (line_reg)
        begin
            ndisp = (nd < CNT_W'(MIN_FRAC_DIGITS)) ? CNT_W'(MIN_FRAC_DIGITS) : nd;
        end
        else
        begin
            ndisp = (nd == '0) ? CNT_W'(1) : nd;
        end
        n_chars = ndisp + CNT_W'(line_reg);
        if (CALC_W'(n_chars) >= CALC_W'(LINE_COLUMNS))
        begin
            column = '0;
        end
        else
        begin
            column = COLUMN_W'(CALC_W'(LINE_COLUMNS) - CALC_W'(n_chars));
        end
    end

    // digits above the limit print as zero padding
    always_comb
    begin
        for (int i = 0; i < DISP_DIGITS; i++)
        begin
            disp_dig[i] = (i < NUM_DIGITS) ? bcd_reg[i*4 +: 4] : 4'd0;
        end
    end

    assign cur_dig   = disp_dig[pos_reg];
    assign at_point  = line_reg && (pos_reg == POS_W'(FRAC_DIGITS));
    assign last_char = !point_next_reg && (pos_reg == '0);

    always_comb
    begin
        line_next       = line_reg;
        value_next      = value_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        pos_next        = pos_reg;
        point_next_next = point_next_reg;
        col_next        = col_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            line_next    = in_data.line;
            value_next   = in_data.value;
            bcd_next     = '0;
            bit_cnt_next = BIT_CNT_W'(VALUE_W - 1);
        end
        if (cmd.shift)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};
            value_next   = {value_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
        end
        if (cmd.count)
        begin
            col_next        = column;
            pos_next        = POS_W'(ndisp - CNT_W'(1));
            point_next_next = 1'b0;
        end
        if (cmd.emit_cursor)
        begin
            out_valid_next          = 1'b1;
            out_data_next.kind      = KIND_CURSOR;
            out_data_next.row       = line_reg;
            out_data_next.column    = col_reg;
            out_data_next.char_code = '0;
            out_data_next.last      = 1'b0;
        end
        if (cmd.emit_char)
        begin
            out_valid_next          = 1'b1;
            out_data_next.kind      = KIND_CHAR;
            out_data_next.row       = line_reg;
            out_data_next.column    = '0;
            out_data_next.last      = last_char;
            if (point_next_reg)
            begin
                out_data_next.char_code = CHAR_POINT;
                point_next_next         = 1'b0;
            end
            else
            begin
                out_data_next.char_code = CHAR_ZERO + {4'd0, cur_dig};
                point_next_next         = at_point;
                pos_next                = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg       <= line_next;
        value_reg      <= value_next;
        bcd_reg        <= bcd_next;
        bit_cnt_reg    <= bit_cnt_next;
        pos_reg        <= pos_next;
        point_next_reg <= point_next_next;
        col_reg        <= col_next;
        out_data_reg   <= out_data_next;
    end

    assign sts.conv_last = (bit_cnt_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.last_char = last_char;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: src/ddf_controller.sv
// ----------------------------------------------------------------------------
// ddf_controller
// Sequencer: accept, convert, count digits, emit cursor, emit characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_controller
    import ddf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ddf_sts_t sts,
    output ddf_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_CURSOR = 3'd3;
    localparam logic [2:0] S_CHARS  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = S_CURSOR;
            end
            S_CURSOR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_cursor = 1'b1;
                    state_next      = S_CHARS;
                end
            end
            S_CHARS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    if (sts.last_char)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: src/decimal_display_formatter_unit.sv
// ----------------------------------------------------------------------------
// decimal_display_formatter_unit
// Prints an unsigned 32-bit value as right-justified decimal ASCII on a
// character display line: one cursor request, then one request per char.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge loads the value; 32 shift-add-3 steps, a
//   digit count and an emit follow, and the cursor request is registered.
// Input: a new value is taken only once the previous run has issued its last
//   of n = 1..11 character requests; an output stall holds each request.
// Reset: rst_n async active low clears the sequencer and the output valid;
//   no request is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_display_formatter_unit
    import ddf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    // Controller issues one command per cycle unless waiting on input or output;
    // datapath reports conversion end, output register free and the final char.
    ddf_cmd_t cmd;
    ddf_sts_t sts;

    // Input requests are taken only while the sequencer is idle; the output
    // register lets the previous run's last request drain meanwhile.
    ddf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Line 1 inserts the point before the last two digits and pads to
    // "0.0d" / "0.dd"; a zero value prints "0" or "0.00".
    ddf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: src/ddf_checker.sv
// ----------------------------------------------------------------------------
// ddf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_checker
    import ddf_pkg::*;
(
    input wire  clk,
    input wire  rst_n,
    input wire  in_valid,
    input wire  in_stall,
    input in_t  in_data,
    input wire  out_valid,
    input wire  out_stall,
    input out_t out_data
);

    // stalled output request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output request changed");

    // one input at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // cursor request carries no character and never ends a run
    a_cursor_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_CURSOR |->
            !out_data.last && out_data.char_code == '0)
        else $error("bad cursor request");

    // character requests carry column 0 and a digit or the point
    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_CHAR |->
            out_data.column == '0 &&
            ((out_data.char_code >= CHAR_ZERO && out_data.char_code <= CHAR_ZERO + 8'd9)
             || out_data.char_code == CHAR_POINT))
        else $error("bad character request");

endmodule

bind decimal_display_formatter_unit ddf_checker u_ddf_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - decimal_display_formatter_unit testbench
// Sends display requests (line, value) and checks every cursor and character
// request that comes out against the table or an independent model. A directed
// table covers zero, padding, digit-count boundaries and the 32-bit maximum.
// A random part follows, with idle bursts on both sides, one long output
// hold and one full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ddf_pkg::*;

    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_REQUESTS = 350;
    localparam int CALM_TAIL       = 60;    // last requests run with no idling
    localparam int HOLD_AT         = 120;   // random request index of the long hold
    localparam int PAUSE_AT        = 220;   // random request index of the drain pause
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 80;    // exceeds the worst-case latency of one request
    // Slowest legal stretch without any handshake is the long hold plus one
    // conversion; a normal request with every result stalled stays well under it.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIR_ROWS        = 20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    in_t  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    out_t out_data;

    decimal_display_formatter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // Requests the display should receive, oldest first
    out_t display_q[$];

    int  failures       = 0;
    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  quiet_cycles   = 0;
    int  drain_pauses   = 0;
    bit  hold_request   = 1'b0;
    bit  hold_done      = 1'b0;
    bit  calm_tail      = 1'b0;

    // ------------------------------------------------------------------------
    // Directed table. A non-empty text gives the expected characters and the
    // cursor column outright; an empty text leaves the row to the formatter
    // model below.
    // ------------------------------------------------------------------------
    bit dir_line [DIR_ROWS] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
    };
    logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
        32'd0,          32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,
        32'd1,          32'd9,          32'd10,         32'd99,
        32'd100,        32'd1,          32'd9,          32'd10,
        32'd1000000000, 32'd1000000000, 32'd999999999,  32'h8000_0000,
        32'd12345,      32'd12345,      32'h5555_5555,  32'hAAAA_AAAA
    };
    string dir_text [DIR_ROWS] = '{
        "0",           "0.00",        "4294967295",  "42949672.95",
        "0.01",        "0.09",        "0.10",        "0.99",
        "1.00",        "1",           "9",           "10",
        "10000000.00", "1000000000",  "9999999.99",  "2147483648",
        "",            "",            "",            ""
    };
    int dir_column [DIR_ROWS] = '{
        15, 12, 6, 5, 12, 12, 12, 12, 12, 15,
        15, 14, 5, 6, 6, 6, 0, 0, 0, 0
    };

    // Cursor request followed by one character request per character, most
    // significant first; last marks the final character.
    function automatic void queue_line(logic row, logic [COLUMN_W-1:0] col,
                                       logic [CHAR_W-1:0] text[$]);
        out_t r;
        r = '{kind: KIND_CURSOR, row: row, column: col, char_code: '0, last: 1'b0};
        display_q.push_back(r);
        foreach (text[i]) begin
            r = '{kind: KIND_CHAR, row: row, column: '0, char_code: text[i],
                  last: (i == text.size() - 1)};
            display_q.push_back(r);
        end
    endfunction

    // Formatter model: decimal digits, then the line 1 point and padding,
    // then the right-justified column (saturating at 0 on overflow).
    function automatic void predict_line(in_t req);
        logic [CHAR_W-1:0]  text[$];   // most significant first
        logic [CHAR_W-1:0]  dig[$];    // least significant first
        logic [VALUE_W-1:0] rest;
        logic [COLUMN_W-1:0] col;
        int i;
        rest = req.value;
        while (rest != 0 && dig.size() < NUM_DIGITS) begin
            dig.push_back(CHAR_ZERO + CHAR_W'(rest % 10));
            rest = rest / 10;
        end
        if (dig.size() == 0) begin
            // zero: "0" or "0.00"
            text.push_front(CHAR_ZERO);
            if (req.line) begin
                text.push_front(CHAR_ZERO);
                text.push_front(CHAR_POINT);
                text.push_front(CHAR_ZERO);
            end
        end else if (!req.line) begin
            foreach (dig[k]) text.push_front(dig[k]);
        end else if (dig.size() == 1) begin
            // 0.0d
            text.push_front(dig[0]);
            text.push_front(CHAR_ZERO);
            text.push_front(CHAR_POINT);
            text.push_front(CHAR_ZERO);
        end else begin
            text.push_front(dig[0]);
            text.push_front(dig[1]);
            text.push_front(CHAR_POINT);
            if (dig.size() == 2)
                text.push_front(CHAR_ZERO);   // 0.dd
            else
                for (i = 2; i < dig.size(); i++) text.push_front(dig[i]);
        end
        col = (text.size() >= LINE_COLUMNS) ? '0 : COLUMN_W'(LINE_COLUMNS - text.size());
        queue_line(req.line, col, text);
    endfunction

    // Random request: mostly values of a random digit count, plus zero,
    // small values (line 1 padding), powers of ten and raw 32-bit patterns.
    function automatic in_t random_request();
        in_t r;
        int pick;
        int nd;
        logic [63:0] lo;
        logic [63:0] hi;
        r.line = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            r.value = '0;
        end else if (pick == 1) begin
            r.value = $urandom_range(120, 0);
        end else if (pick == 2) begin
            r.value = $urandom;
        end else begin
            nd = $urandom_range(1, 10);
            lo = 64'd1;
            repeat (nd - 1) lo = lo * 10;
            hi = (nd == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
            if (pick == 3)
                r.value = $urandom_range(0, 1) ? lo[31:0] : hi[31:0];
            else
                r.value = $urandom_range(hi[31:0], lo[31:0]);
        end
        return r;
    endfunction

    // Offer one request and hold it until accepted; the expected display
    // requests are queued at the accepting edge.
    task automatic send_request(input in_t req, input string text, input int column);
        logic [CHAR_W-1:0] chars[$];
        int i;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        if (text.len() == 0) begin
            predict_line(req);
        end else begin
            for (i = 0; i < text.len(); i++) chars.push_back(text.getc(i));
            queue_line(req.line, COLUMN_W'(column), chars);
        end
        requests_sent++;
    endtask

    // Sender idle burst, with junk on the data bus while valid is low
    task automatic sender_gap();
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            in_data  <= in_t'({1'($urandom_range(0, 1)), 32'($urandom)});
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [CHAR_W-1:0] want,
                               logic [CHAR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int i;
        in_t req;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            sender_gap();
            req.line  = dir_line[i];
            req.value = dir_value[i];
            send_request(req, dir_text[i], dir_column[i]);
        end

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == HOLD_AT)
                hold_request = 1'b1;   // receiver freezes; keep offering requests
            if (i == PAUSE_AT) begin
                // let the block run completely dry before the next request
                in_valid <= 1'b0;
                do @(posedge clk); while (display_q.size() != 0);
                drain_pauses++;
            end
            if (i == RANDOM_REQUESTS - CALM_TAIL)
                calm_tail = 1'b1;
            sender_gap();
            send_request(random_request(), "", 0);
        end
        in_valid <= 1'b0;

        while (display_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests (%0d from the table), %0d display requests checked",
                 requests_sent, DIR_ROWS, results_seen);
        $display("long output hold %0s, %0d full drain pause(s), %0d failure(s)",
                 hold_done ? "done" : "missed", drain_pauses, failures);
        if (failures == 0)
            $display("decimal_display_formatter_unit verification clean");
        else
            $display("decimal_display_formatter_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, free-running stretches, one long hold
    // while the sender keeps pushing, nothing during the calm tail.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int pick;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
                hold_done    = 1'b1;
            end else if (calm_tail) begin
                out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 14)) @(posedge clk);
                    out_stall <= 1'b0;
                end else if (pick == 2) begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checker and watchdog. Both sample pre-edge values, so the
    // nonblocking drives above cannot race them.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_t want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles, %0d display requests outstanding",
                         quiet_cycles, display_q.size());
                $display("decimal_display_formatter_unit verification failed");
                $finish;
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (display_q.size() == 0) begin
                    $error("display request with nothing pending: kind %0d char %0d",
                           out_data.kind, out_data.char_code);
                    failures++;
                end else begin
                    want = display_q.pop_front();
                    check_field("kind",      CHAR_W'(want.kind),   CHAR_W'(out_data.kind));
                    check_field("row",       CHAR_W'(want.row),    CHAR_W'(out_data.row));
                    check_field("column",    CHAR_W'(want.column), CHAR_W'(out_data.column));
                    check_field("char_code", want.char_code,       out_data.char_code);
                    check_field("last",      CHAR_W'(want.last),   CHAR_W'(out_data.last));
                end
            end
        end
    end

endmodule
